>>> design/swdm_pkg.sv
// shared types and constants for the stepper wave drive mover
// no dependencies; used by the divide stages and the top level
package swdm_pkg;

  // one motor step spans this many 1/256 degree units
  localparam int unsigned StepUnits   = 45;
  localparam logic [31:0] PeriodReset = 32'd144000;

  // reciprocal of 45 scaled by 2**37, rounded down
  localparam logic [31:0] Recip      = 32'd3054198966;
  localparam int unsigned RecipShift = 37;

  // magnitude of a 32-bit angle over 45 fits in 26 bits
  localparam int unsigned QuotW = 26;

  typedef enum logic [1:0] {
    ActTick = 2'd0,
    ActRel  = 2'd1,
    ActAbs  = 2'd2
  } act_e;

  // angle split into step quotient and remainder flag
  typedef struct packed {
    act_e             act;
    logic             neg;
    logic [QuotW-1:0] quot;
    logic             rem_nz;
  } swdm_quot_t;

endpackage

>>> design/swdm_if.sv
// valid/ready channel interfaces for command items and result items
// no dependencies
interface swdm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] target_angle;

  modport source (output valid, action, target_angle, input ready);
  modport sink   (input valid, action, target_angle, output ready);
endinterface

interface swdm_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         coil_drive;
  logic               stopped;
  logic signed [31:0] position;

  modport source (output valid, coil_drive, stopped, position, input ready);
  modport sink   (input valid, coil_drive, stopped, position, output ready);
endinterface

>>> design/swdm_div45.sv
// three-stage pipeline: input register, reciprocal multiply, remainder fix
// splits the target angle into trunc(angle/45) and a nonzero-remainder flag
// depends on swdm_pkg and swdm_in_if
module swdm_div45 (
  input  logic                clk_i,
  input  logic                rst_ni,
  swdm_in_if.sink             in_i,
  output logic                quo_valid_o,
  input  logic                quo_ready_i,
  output swdm_pkg::swdm_quot_t quo_o
);
  import swdm_pkg::*;

  logic             a_vld_q, b_vld_q, c_vld_q;
  logic             a_rdy, b_rdy, c_rdy;
  act_e             a_act_q, b_act_q;
  logic             a_neg_q, b_neg_q;
  logic [31:0]      a_mag_q, b_mag_q;
  logic [31:0]      in_mag;
  logic [63:0]      prod;
  logic [QuotW-1:0] b_qest_q;
  logic [31:0]      prod45;
  logic [31:0]      rem_raw;
  logic             fix;
  logic [6:0]       rem_fix;
  swdm_quot_t       c_d, c_q;

  // stage readiness, back to front
  assign c_rdy      = !c_vld_q || quo_ready_i;
  assign b_rdy      = !b_vld_q || c_rdy;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign in_i.ready = a_rdy;

  // magnitude of the incoming angle
  assign in_mag = in_i.target_angle[31] ? 32'(-in_i.target_angle)
                                        : 32'(in_i.target_angle);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= in_i.valid;
      if (b_rdy) b_vld_q <= a_vld_q;
      if (c_rdy) c_vld_q <= b_vld_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_i.valid && a_rdy) begin
      a_act_q <= act_e'(in_i.action);
      a_neg_q <= in_i.target_angle[31];
      a_mag_q <= in_mag;
    end
  end

  // quotient estimate, equal to the true quotient or one below
  assign prod = 64'(a_mag_q) * 64'(Recip);

  always_ff @(posedge clk_i) begin
    if (a_vld_q && b_rdy) begin
      b_act_q  <= a_act_q;
      b_neg_q  <= a_neg_q;
      b_mag_q  <= a_mag_q;
      b_qest_q <= prod[RecipShift+QuotW-1:RecipShift];
    end
  end

  // remainder check and one-step correction
  assign prod45  = 32'(b_qest_q) * 32'(StepUnits);
  assign rem_raw = b_mag_q - prod45;
  assign fix     = rem_raw[6:0] >= 7'(StepUnits);
  assign rem_fix = fix ? rem_raw[6:0] - 7'(StepUnits) : rem_raw[6:0];

  always_comb begin
    c_d.act    = b_act_q;
    c_d.neg    = b_neg_q;
    c_d.quot   = b_qest_q + QuotW'(fix);
    c_d.rem_nz = rem_fix != 7'd0;
  end

  always_ff @(posedge clk_i) begin
    if (b_vld_q && c_rdy) begin
      c_q <= c_d;
    end
  end

  assign quo_valid_o = c_vld_q;
  assign quo_o       = c_q;
endmodule

>>> design/stepper_wave_drive_mover.sv
// four-phase wave drive stepper controller, top level
// path: input, multiply and fix registers of swdm_div45, then the result register
// throughput: one item per cycle while the result is taken; the motor state updates in one stage
// the angle divide by 45 runs in the three stages of swdm_div45
// reset: counts, position, phase and coils clear; step_period returns to 144000
// depends on swdm_pkg, swdm_if and swdm_div45
module stepper_wave_drive_mover (
  input  logic        clk_i,
  input  logic        rst_ni,
  swdm_in_if.sink     in_i,
  swdm_out_if.source  out_o,
  input  logic        step_period_we_i,
  input  logic [31:0] step_period_i
);
  import swdm_pkg::*;

  logic        quo_valid, quo_ready, upd;
  swdm_quot_t  quo;

  logic        out_vld_q;
  logic [31:0] period_q;
  logic [31:0] steps_q, steps_d;
  logic [31:0] pos_q, pos_d;
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  coil_q, coil_d;
  logic [31:0] tick_q, tick_d;

  logic [32:0] tick_nxt;
  logic        fire;
  logic [26:0] qs;
  logic [33:0] kd, k;
  logic        k_pos, k_neg;
  logic [31:0] abs_steps;

  swdm_div45 u_div45 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .quo_valid_o (quo_valid),
    .quo_ready_i (quo_ready),
    .quo_o       (quo)
  );

  // state advances when an item moves into the result register
  assign quo_ready = !out_vld_q || out_o.ready;
  assign upd       = quo_valid && quo_ready;

  // tick counter wrap check, period zero acts as one
  assign tick_nxt = 33'(tick_q) + 33'd1;
  assign fire     = tick_nxt >= {1'b0, period_q};

  // signed step quotient and absolute move target
  assign qs    = quo.neg ? -{1'b0, quo.quot} : {1'b0, quo.quot};
  assign kd    = {{7{qs[26]}}, qs} - {{2{pos_q[31]}}, pos_q};
  assign k_pos = !kd[33] && (kd != 34'd0);
  assign k_neg = kd[33];

  always_comb begin
    k = kd;
    if (k_pos && quo.neg && quo.rem_nz) begin
      k = kd - 34'd1;
    end else if (k_neg && !quo.neg && quo.rem_nz) begin
      k = kd + 34'd1;
    end
  end

  // saturate to signed 32 bits
  always_comb begin
    if (k[33:31] == 3'b000 || k[33:31] == 3'b111) begin
      abs_steps = k[31:0];
    end else if (k[33]) begin
      abs_steps = 32'h8000_0000;
    end else begin
      abs_steps = 32'h7fff_ffff;
    end
  end

  // next motor state
  always_comb begin
    steps_d = steps_q;
    pos_d   = pos_q;
    phase_d = phase_q;
    coil_d  = coil_q;
    tick_d  = tick_q;
    unique case (quo.act)
      ActTick: begin
        if (fire) begin
          tick_d = 32'd0;
          if (!steps_q[31] && steps_q != 32'd0) begin
            steps_d = steps_q - 32'd1;
            pos_d   = pos_q + 32'd1;
            phase_d = phase_q + 2'd1;
            coil_d  = 4'b0001 << (phase_q + 2'd1);
          end else if (steps_q[31]) begin
            steps_d = steps_q + 32'd1;
            pos_d   = pos_q - 32'd1;
            phase_d = phase_q - 2'd1;
            coil_d  = 4'b0001 << (phase_q - 2'd1);
          end else begin
            coil_d = 4'b0000;
          end
        end else begin
          tick_d = tick_nxt[31:0];
        end
      end
      ActRel:  steps_d = {{5{qs[26]}}, qs};
      ActAbs:  steps_d = abs_steps;
      default: ;
    endcase
  end

  // state registers and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      period_q  <= PeriodReset;
      steps_q   <= '0;
      pos_q     <= '0;
      phase_q   <= '0;
      coil_q    <= '0;
      tick_q    <= '0;
    end else begin
      if (step_period_we_i) period_q <= step_period_i;
      if (quo_ready) out_vld_q <= quo_valid;
      if (upd) begin
        steps_q <= steps_d;
        pos_q   <= pos_d;
        phase_q <= phase_d;
        coil_q  <= coil_d;
        tick_q  <= tick_d;
      end
    end
  end

  // result fields mirror the state after the latest update
  assign out_o.valid      = out_vld_q;
  assign out_o.coil_drive = coil_q;
  assign out_o.stopped    = steps_q == 32'd0;
  assign out_o.position   = pos_q;

  // energized coil always matches the phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    coil_q != 4'b0000 |-> coil_q == (4'b0001 << phase_q))
    else $error("coil drive does not match phase");

  // motor state holds unless an item enters the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd |=> $stable(pos_q) && $stable(steps_q) && $stable(tick_q))
    else $error("state changed without an update");

  // a held result keeps its position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |=> $stable(pos_q) && $stable(coil_q))
    else $error("stalled result changed");
endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for the stepper wave drive mover
// drives command transfers, predicts coil drive, stop flag and position per transfer
// depends on swdm_pkg, swdm_if and stepper_wave_drive_mover
module testbench;
  import swdm_pkg::*;

  // action code that the block ignores
  localparam logic [1:0] ActNone = 2'd3;
  localparam longint StepAngle = 45;
  localparam int DrainCycles = 6;
  localparam int HoldCycles = 60;
  localparam int QuietLimit = 2000;
  localparam int PhaseItems = 100;
  localparam int NumPhases = 9;

  typedef struct packed {
    logic [3:0]         coil;
    logic               stopped;
    logic signed [31:0] pos;
  } drive_result_t;

  typedef struct {
    bit                 cfg_en;
    logic [31:0]        cfg_val;
    logic [1:0]         act;
    logic signed [31:0] angle;
    bit                 has_exp;
    drive_result_t      exp;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        step_period_we_i;
  logic [31:0] step_period_i;

  swdm_in_if  cmd_ch ();
  swdm_out_if drv_ch ();

  stepper_wave_drive_mover dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (cmd_ch),
    .out_o            (drv_ch),
    .step_period_we_i (step_period_we_i),
    .step_period_i    (step_period_i)
  );

  // predicted motor state and register copy
  logic [31:0]        pred_period = PeriodReset;
  logic signed [31:0] pred_left = '0;
  logic signed [31:0] pred_pos = '0;
  logic [1:0]         pred_phase = '0;
  logic [3:0]         pred_coil = '0;
  logic [31:0]        pred_ticks = '0;

  drive_result_t pending_drive[$];
  stim_row_t     stim_table[$];

  int  mismatches = 0;
  int  cmds_sent = 0;
  int  drives_checked = 0;
  int  coil_pulses = 0;
  int  period_writes = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  drive_result_t got_drive;
  drive_result_t want_drive;

  // clock, period 2
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic signed [31:0] sat_steps(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // advance the predicted state by one command and return its drive result
  function automatic drive_result_t predict_drive(input logic [1:0] act,
                                                  input logic signed [31:0] angle);
    logic [31:0]   next_tick;
    longint        diff;
    drive_result_t res;
    case (act)
      ActTick: begin
        next_tick = pred_ticks + 32'd1;
        if (next_tick >= pred_period || next_tick == 32'd0) begin
          pred_ticks = '0;
          // one step action toward zero remaining steps
          if (pred_left > 0) begin
            pred_left  = pred_left - 1;
            pred_pos   = pred_pos + 1;
            pred_phase = pred_phase + 2'd1;
            pred_coil  = 4'b0001 << pred_phase;
          end else if (pred_left < 0) begin
            pred_left  = pred_left + 1;
            pred_pos   = pred_pos - 1;
            pred_phase = pred_phase - 2'd1;
            pred_coil  = 4'b0001 << pred_phase;
          end else begin
            pred_coil = '0;
          end
        end else begin
          pred_ticks = next_tick;
        end
      end
      ActRel: pred_left = sat_steps(longint'(angle) / StepAngle);
      ActAbs: begin
        diff = longint'(angle) - StepAngle * longint'(pred_pos);
        pred_left = sat_steps(diff / StepAngle);
      end
      default: ;
    endcase
    res.coil    = pred_coil;
    res.stopped = (pred_left == 0);
    res.pos     = pred_pos;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch: %s on result %0d, got %0h, expected %0h",
             what, drives_checked, got, want);
  endtask

  // offer one command, wait for its transfer, queue its expected drive
  task automatic send_cmd(input logic [1:0] act, input logic signed [31:0] angle,
                          input bit has_exp, input drive_result_t exp_drive);
    int            gap;
    drive_result_t pred;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_ch.valid        = 1'b1;
    cmd_ch.action       = act;
    cmd_ch.target_angle = angle;
    do @(posedge clk_i); while (!cmd_ch.ready);
    pred = predict_drive(act, angle);
    pending_drive.push_back(has_exp ? exp_drive : pred);
    cmds_sent++;
    @(negedge clk_i);
  endtask

  // wait until the block is empty, then write the step period
  task automatic write_period(input logic [31:0] value);
    cmd_ch.valid = 1'b0;
    while (pending_drive.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    step_period_we_i = 1'b1;
    step_period_i    = value;
    @(negedge clk_i);
    step_period_we_i = 1'b0;
    pred_period = value;
    period_writes++;
  endtask

  task automatic add_row(input bit cfg_en, input logic [31:0] cfg_val,
                         input logic [1:0] act, input logic signed [31:0] angle,
                         input bit has_exp, input drive_result_t exp_drive);
    stim_row_t row;
    row.cfg_en  = cfg_en;
    row.cfg_val = cfg_val;
    row.act     = act;
    row.angle   = angle;
    row.has_exp = has_exp;
    row.exp     = exp_drive;
    stim_table.push_back(row);
  endtask

  // drive result checker
  always @(posedge clk_i) begin
    if (rst_ni && drv_ch.valid && drv_ch.ready) begin
      got_drive = '{drv_ch.coil_drive, drv_ch.stopped, drv_ch.position};
      if (pending_drive.size() == 0) begin
        report_mismatch("unexpected result", got_drive.pos, '0);
      end else begin
        want_drive = pending_drive.pop_front();
        if (got_drive.coil !== want_drive.coil)
          report_mismatch("coil_drive", 32'(got_drive.coil), 32'(want_drive.coil));
        if (got_drive.stopped !== want_drive.stopped)
          report_mismatch("stopped", 32'(got_drive.stopped), 32'(want_drive.stopped));
        if (got_drive.pos !== want_drive.pos)
          report_mismatch("position", got_drive.pos, want_drive.pos);
      end
      if (got_drive.coil != 4'd0) coil_pulses++;
      drives_checked++;
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    int gap;
    drv_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        drv_ch.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        drv_ch.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      drv_ch.ready = 1'b1;
      do @(posedge clk_i); while (!drv_ch.valid);
      @(negedge clk_i);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((cmd_ch.valid && cmd_ch.ready) || (drv_ch.valid && drv_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transfer for %0d cycles", QuietLimit);
    $display("Mismatches found");
    $finish;
  end

  // main sequence
  initial begin
    stim_row_t          row;
    drive_result_t      no_exp;
    logic [31:0]        phase_period;
    logic [1:0]         act;
    logic signed [31:0] angle;
    int                 pick;
    no_exp              = '0;
    rst_ni              = 1'b0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.action       = ActTick;
    cmd_ch.target_angle = '0;
    step_period_we_i    = 1'b0;
    step_period_i       = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table: reset outputs, small moves, extremes, zero period
    add_row(0, 0, ActTick, 0, 1, '{4'd0, 1'b1, 32'sd0});
    add_row(0, 0, ActNone, -1, 1, '{4'd0, 1'b1, 32'sd0});
    add_row(0, 0, ActRel, 44, 1, '{4'd0, 1'b1, 32'sd0});
    add_row(0, 0, ActRel, -44, 1, '{4'd0, 1'b1, 32'sd0});
    add_row(0, 0, ActRel, 45, 1, '{4'd0, 1'b0, 32'sd0});
    add_row(0, 0, ActTick, 0, 1, '{4'd0, 1'b0, 32'sd0});
    add_row(1, 1, ActTick, 0, 1, '{4'd2, 1'b1, 32'sd1});
    add_row(0, 0, ActTick, 0, 1, '{4'd0, 1'b1, 32'sd1});
    add_row(0, 0, ActRel, -90, 1, '{4'd0, 1'b0, 32'sd1});
    add_row(0, 0, ActTick, 0, 1, '{4'd1, 1'b0, 32'sd0});
    add_row(0, 0, ActTick, 0, 1, '{4'd8, 1'b1, -32'sd1});
    add_row(0, 0, ActAbs, 135, 0, no_exp);
    add_row(0, 0, ActTick, 0, 0, no_exp);
    add_row(0, 0, ActAbs, -100, 0, no_exp);
    add_row(0, 0, ActRel, 32'sh7fffffff, 0, no_exp);
    add_row(0, 0, ActRel, 32'sh80000000, 0, no_exp);
    add_row(0, 0, ActAbs, 32'sh7fffffff, 0, no_exp);
    add_row(0, 0, ActAbs, 32'sh80000000, 0, no_exp);
    add_row(1, 0, ActTick, 0, 0, no_exp);
    add_row(0, 0, ActTick, 0, 0, no_exp);
    add_row(1, 2, ActRel, 269, 0, no_exp);
    add_row(0, 0, ActTick, 0, 0, no_exp);
    add_row(0, 0, ActTick, 0, 0, no_exp);
    add_row(0, 0, ActTick, 0, 0, no_exp);
    add_row(1, 32'hffffffff, ActTick, 0, 0, no_exp);
    add_row(0, 0, ActNone, 32'sh80000000, 0, no_exp);

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.cfg_en) write_period(row.cfg_val);
      send_cmd(row.act, row.angle, row.has_exp, row.exp);
    end

    // random phases, each under its own step period
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: phase_period = 32'd1;
        1: phase_period = 32'd3;
        2: phase_period = 32'd0;
        3: phase_period = 32'd2;
        4: phase_period = $urandom_range(1, 8);
        5: phase_period = 32'd1;
        6: phase_period = 32'hffffffff;
        7: phase_period = $urandom_range(1, 16);
        default: phase_period = 32'd1;
      endcase
      write_period(phase_period);
      idle_on  = !(ph == 0 || ph == 3);
      hold_req = (ph == 3);
      for (int n = 0; n < PhaseItems; n++) begin
        // sender pause until every queued drive has come back
        if (ph == 5 && n == PhaseItems / 2) begin
          cmd_ch.valid = 1'b0;
          while (pending_drive.size() != 0) @(negedge clk_i);
        end
        pick = $urandom_range(0, 99);
        if (pick < 65) act = ActTick;
        else if (pick < 80) act = ActRel;
        else if (pick < 95) act = ActAbs;
        else act = ActNone;
        if ($urandom_range(0, 9) == 0) angle = $urandom;
        else angle = $signed($urandom_range(0, 1800)) - 32'sd900;
        send_cmd(act, angle, 0, no_exp);
      end
    end

    // let the block empty out, then keep the inputs quiet before the summary
    cmd_ch.valid = 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d commands over %0d step period writes", cmds_sent, period_writes);
    $display("checked %0d drive results, %0d with a coil energized",
             drives_checked, coil_pulses);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
